// ===== hdl/srb_pkg.sv =====
// Shared constants for the segment register builder.
package srb_pkg;

  localparam int unsigned SEG_PER_SPACE    = 8;
  localparam int unsigned CLICKS_PER_SEG   = 128;
  localparam int unsigned MAX_SPACE_CLICKS = 1023;
  localparam int unsigned TABLE_DEPTH      = 2 * SEG_PER_SPACE;
  localparam int unsigned TABLE_AW         = $clog2(TABLE_DEPTH);
  localparam int unsigned SEG_SHIFT        = $clog2(CLICKS_PER_SEG);
  localparam int unsigned LEN_W            = SEG_SHIFT;
  localparam int unsigned WORD_W           = 32;

  localparam int unsigned CLICKS_W   = 10;
  localparam int unsigned ADDR_W     = 16;
  localparam int unsigned DESC_W     = 16;
  localparam int unsigned DESC_OUT_W = 15;
  localparam int unsigned ACC_W      = 3;
  localparam int unsigned UA_W       = 7;

  localparam logic [ACC_W-1:0] ACC_RW = 3'd6;

  localparam logic [1:0] CFG_EIGHT_SEG = 2'd0;
  localparam logic [1:0] CFG_MEM_LIMIT = 2'd1;
  localparam logic [1:0] CFG_USER_AREA = 2'd2;

endpackage

// ===== hdl/segment_register_builder_top.sv =====
// Top level of the segment register builder: size check, table build and emit.
//
// A request is taken when start_i is high and busy_o is low. The sizes are
// checked in the following cycle. A refused request gives a single word with
// error_o and last_o high, registered from the check state.
// An accepted request writes the 16-entry table, one entry per cycle:
// text segments, padding, data segments, padding, stack segments downward,
// then, without separate spaces, a read-and-write-back pass that mirrors
// the lower half into the upper half. The table is then read one entry per
// cycle and 8 or 16 words follow on consecutive cycles, each marked by
// out_valid_o, the final one with last_o.
// The receiver cannot stall; every word is shown for one cycle only.
// Configuration is written on its own channel (cfg_ready_o is always high);
// the user must write it only while the block is idle, as the block itself
// does not enforce this. Reset loads eight_segment_cpu 0, memory_limit
// 65535 and user_area_clicks 16; the table content is undefined until
// a request writes it.
module segment_register_builder_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [srb_pkg::CLICKS_W-1:0]  text_clicks_i,
  input  logic [srb_pkg::CLICKS_W-1:0]  data_clicks_i,
  input  logic [srb_pkg::CLICKS_W-1:0]  stack_clicks_i,
  input  logic                          separate_i,
  input  logic [srb_pkg::ACC_W-1:0]     text_access_i,
  input  logic [srb_pkg::ADDR_W-1:0]    text_base_i,
  input  logic [srb_pkg::ADDR_W-1:0]    data_base_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [1:0]                    cfg_index_i,
  input  logic [15:0]                   cfg_data_i,
  output logic                          out_valid_o,
  output logic [srb_pkg::TABLE_AW-1:0]  reg_index_o,
  output logic [srb_pkg::ADDR_W-1:0]    proto_address_o,
  output logic [srb_pkg::ADDR_W-1:0]    hw_address_o,
  output logic [srb_pkg::DESC_OUT_W-1:0] descriptor_o,
  output logic                          error_o,
  output logic                          last_o
);

  import srb_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_TEXT,
    ST_TPAD,
    ST_DATA,
    ST_DPAD,
    ST_SPAD,
    ST_STACK,
    ST_MIRROR,
    ST_EMIT
  } state_e;

  function automatic logic [DESC_W-1:0] mk_desc(input logic [LEN_W-1:0] len,
                                                input logic txt,
                                                input logic exp_down,
                                                input logic [ACC_W-1:0] acc);
    mk_desc = {1'b0, len, 3'b000, txt, exp_down, acc};
  endfunction

  localparam logic [LEN_W-1:0]    FULL_LEN  = LEN_W'(CLICKS_PER_SEG - 1);
  localparam logic [ADDR_W-1:0]   SEG_STEP  = ADDR_W'(CLICKS_PER_SEG);
  localparam logic [CLICKS_W-1:0] REM_STEP  = CLICKS_W'(CLICKS_PER_SEG);
  localparam logic [11:0]         MAX_SPACE = 12'(MAX_SPACE_CLICKS);
  localparam logic [4:0]          SEG_LIM   = 5'(SEG_PER_SPACE);
  localparam logic [4:0]          TAB_LIM   = 5'(TABLE_DEPTH);

  state_e state_q, state_d;

  logic                  eight_q;
  logic [15:0]           limit_q;
  logic [UA_W-1:0]       ua_q;

  logic [CLICKS_W-1:0]   nt_q, nd_q, ns_q;
  logic                  sep_q;
  logic [ACC_W-1:0]      acc_q;
  logic [ADDR_W-1:0]     tbase_q, dbase_q;

  logic [4:0]            idx_q, idx_d;
  logic [ADDR_W-1:0]     addr_q, addr_d;
  logic [CLICKS_W-1:0]   rem_q, rem_d;

  logic                  rd_valid_q, rd_valid_d;
  logic [TABLE_AW-1:0]   rd_idx_q, rd_idx_d;
  logic                  rd_last_q, rd_last_d;

  logic                  out_valid_q, out_valid_d;
  logic [TABLE_AW-1:0]   out_idx_q, out_idx_d;
  logic [ADDR_W-1:0]     out_pa_q, out_pa_d;
  logic [ADDR_W-1:0]     out_hw_q, out_hw_d;
  logic [DESC_OUT_W-1:0] out_desc_q, out_desc_d;
  logic                  out_err_q, out_err_d;
  logic                  out_last_q, out_last_d;

  logic                  ram_we;
  logic [TABLE_AW-1:0]   ram_waddr, ram_raddr;
  logic [WORD_W-1:0]     ram_wdata, ram_rdata;

  logic [3:0]            seg_t, seg_d, seg_s;
  logic [4:0]            seg_all, seg_ds;
  logic [11:0]           total, ds_total;
  logic                  sizes_ok;
  logic                  rem_full;
  logic [TABLE_AW-1:0]   last_k;
  logic [ADDR_W-1:0]     rd_pa;
  logic [DESC_W-1:0]     rd_desc;
  logic [LEN_W-1:0]      stack_len;
  logic                  take;

  srb_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign take        = start_i && (state_q == ST_IDLE);
  assign busy_o      = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  assign seg_t    = 4'((11'(nt_q) + 11'(CLICKS_PER_SEG - 1)) >> SEG_SHIFT);
  assign seg_d    = 4'((11'(nd_q) + 11'(CLICKS_PER_SEG - 1)) >> SEG_SHIFT);
  assign seg_s    = 4'((11'(ns_q) + 11'(CLICKS_PER_SEG - 1)) >> SEG_SHIFT);
  assign seg_all  = 5'(seg_t) + 5'(seg_d) + 5'(seg_s);
  assign seg_ds   = 5'(seg_d) + 5'(seg_s);
  assign ds_total = 12'(nd_q) + 12'(ns_q) + 12'(ua_q);
  assign total    = 12'(nt_q) + ds_total;

  always_comb begin
    if (sep_q) begin
      sizes_ok = !eight_q && (5'(seg_t) <= SEG_LIM) && (seg_ds <= SEG_LIM) &&
                 (12'(nt_q) <= MAX_SPACE) && (ds_total <= MAX_SPACE);
    end else begin
      sizes_ok = (seg_all <= SEG_LIM) && (total <= MAX_SPACE);
    end
    sizes_ok = sizes_ok && ({4'b0, total} <= limit_q);
  end

  assign rem_full  = (rem_q >= REM_STEP);
  assign last_k    = eight_q ? TABLE_AW'(SEG_PER_SPACE - 1) : TABLE_AW'(TABLE_DEPTH - 1);
  assign rd_pa     = ram_rdata[WORD_W-1:DESC_W];
  assign rd_desc   = ram_rdata[DESC_W-1:0];
  assign stack_len = LEN_W'(8'(CLICKS_PER_SEG) - 8'(rem_q));

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    addr_d      = addr_q;
    rem_d       = rem_q;
    rd_valid_d  = 1'b0;
    rd_idx_d    = rd_idx_q;
    rd_last_d   = rd_last_q;
    out_valid_d = 1'b0;
    out_idx_d   = out_idx_q;
    out_pa_d    = out_pa_q;
    out_hw_d    = out_hw_q;
    out_desc_d  = out_desc_q;
    out_err_d   = out_err_q;
    out_last_d  = out_last_q;
    ram_we      = 1'b0;
    ram_waddr   = idx_q[TABLE_AW-1:0];
    ram_wdata   = '0;
    ram_raddr   = idx_q[TABLE_AW-1:0];

    if (rd_valid_q) begin
      out_valid_d = 1'b1;
      out_idx_d   = rd_idx_q;
      out_pa_d    = rd_pa;
      out_hw_d    = rd_pa + (rd_desc[4] ? tbase_q : dbase_q);
      out_desc_d  = rd_desc[DESC_OUT_W-1:0];
      out_err_d   = 1'b0;
      out_last_d  = rd_last_q;
    end

    case (state_q)
      ST_IDLE: begin
        if (take) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!sizes_ok) begin
          out_valid_d = 1'b1;
          out_idx_d   = '0;
          out_pa_d    = '0;
          out_hw_d    = '0;
          out_desc_d  = '0;
          out_err_d   = 1'b1;
          out_last_d  = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          idx_d   = '0;
          addr_d  = '0;
          rem_d   = nt_q;
          state_d = ST_TEXT;
        end
      end
      ST_TEXT: begin
        if (rem_full) begin
          ram_we    = 1'b1;
          ram_wdata = {addr_q, mk_desc(FULL_LEN, 1'b1, 1'b0, acc_q)};
          idx_d     = idx_q + 5'd1;
          addr_d    = addr_q + SEG_STEP;
          rem_d     = rem_q - REM_STEP;
        end else begin
          if (rem_q != '0) begin
            ram_we    = 1'b1;
            ram_wdata = {addr_q, mk_desc(LEN_W'(rem_q - 1'b1), 1'b1, 1'b0, acc_q)};
            idx_d     = idx_q + 5'd1;
          end
          if (sep_q) begin
            state_d = ST_TPAD;
          end else begin
            addr_d  = ADDR_W'(ua_q);
            rem_d   = nd_q;
            state_d = ST_DATA;
          end
        end
      end
      ST_TPAD: begin
        if (idx_q >= SEG_LIM) begin
          addr_d  = ADDR_W'(ua_q);
          rem_d   = nd_q;
          state_d = ST_DATA;
        end else begin
          ram_we = 1'b1;
          idx_d  = idx_q + 5'd1;
        end
      end
      ST_DATA: begin
        if (rem_full) begin
          ram_we    = 1'b1;
          ram_wdata = {addr_q, mk_desc(FULL_LEN, 1'b0, 1'b0, ACC_RW)};
          idx_d     = idx_q + 5'd1;
          addr_d    = addr_q + SEG_STEP;
          rem_d     = rem_q - REM_STEP;
        end else begin
          if (rem_q != '0) begin
            ram_we    = 1'b1;
            ram_wdata = {addr_q, mk_desc(LEN_W'(rem_q - 1'b1), 1'b0, 1'b0, ACC_RW)};
            idx_d     = idx_q + 5'd1;
          end
          addr_d  = addr_q + ADDR_W'(rem_q) + ADDR_W'(ns_q);
          rem_d   = ns_q;
          state_d = ST_DPAD;
        end
      end
      ST_DPAD: begin
        if (idx_q >= SEG_LIM) begin
          state_d = sep_q ? ST_SPAD : ST_STACK;
        end else begin
          ram_we = 1'b1;
          idx_d  = idx_q + 5'd1;
        end
      end
      ST_SPAD: begin
        if (idx_q >= TAB_LIM) begin
          state_d = ST_STACK;
        end else begin
          ram_we = 1'b1;
          idx_d  = idx_q + 5'd1;
        end
      end
      ST_STACK: begin
        ram_waddr = TABLE_AW'(idx_q - 5'd1);
        if (rem_full) begin
          ram_we    = 1'b1;
          ram_wdata = {addr_q - SEG_STEP, mk_desc(FULL_LEN, 1'b0, 1'b0, ACC_RW)};
          idx_d     = idx_q - 5'd1;
          addr_d    = addr_q - SEG_STEP;
          rem_d     = rem_q - REM_STEP;
        end else begin
          if (rem_q != '0) begin
            ram_we    = 1'b1;
            ram_wdata = {addr_q - SEG_STEP, mk_desc(stack_len, 1'b0, 1'b1, ACC_RW)};
          end
          idx_d   = '0;
          state_d = sep_q ? ST_EMIT : ST_MIRROR;
        end
      end
      ST_MIRROR: begin
        ram_raddr = {1'b0, idx_q[TABLE_AW-2:0]};
        ram_waddr = {1'b1, 3'(idx_q - 5'd1)};
        ram_wdata = ram_rdata;
        ram_we    = (idx_q != '0);
        if (idx_q >= SEG_LIM) begin
          idx_d   = '0;
          state_d = ST_EMIT;
        end else begin
          idx_d = idx_q + 5'd1;
        end
      end
      ST_EMIT: begin
        rd_valid_d = 1'b1;
        rd_idx_d   = idx_q[TABLE_AW-1:0];
        rd_last_d  = (idx_q[TABLE_AW-1:0] == last_k);
        if (idx_q[TABLE_AW-1:0] == last_k) begin
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_q + 5'd1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      eight_q     <= 1'b0;
      limit_q     <= 16'hFFFF;
      ua_q        <= UA_W'(16);
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_valid_q  <= rd_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_EIGHT_SEG: eight_q <= cfg_data_i[0];
          CFG_MEM_LIMIT: limit_q <= cfg_data_i;
          CFG_USER_AREA: ua_q    <= cfg_data_i[UA_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      nt_q    <= text_clicks_i;
      nd_q    <= data_clicks_i;
      ns_q    <= stack_clicks_i;
      sep_q   <= separate_i;
      acc_q   <= text_access_i;
      tbase_q <= text_base_i;
      dbase_q <= data_base_i;
    end
    idx_q      <= idx_d;
    addr_q     <= addr_d;
    rem_q      <= rem_d;
    rd_idx_q   <= rd_idx_d;
    rd_last_q  <= rd_last_d;
    out_idx_q  <= out_idx_d;
    out_pa_q   <= out_pa_d;
    out_hw_q   <= out_hw_d;
    out_desc_q <= out_desc_d;
    out_err_q  <= out_err_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o     = out_valid_q;
  assign reg_index_o     = out_idx_q;
  assign proto_address_o = out_pa_q;
  assign hw_address_o    = out_hw_q;
  assign descriptor_o    = out_desc_q;
  assign error_o         = out_err_q;
  assign last_o          = out_last_q;

endmodule

// ===== hdl/srb_ram.sv =====
// Generic single write, single read port RAM with registered read data.
module srb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
